// File: src/tts_pkg.sv
// Shared types, sizes and codes for the timer table scheduler.
`default_nettype none
package tts_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIME_BITS  = 32;
    localparam int ID_BITS    = 32;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int DIVCNT_W   = $clog2(TIME_BITS + 1);

    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 72;
    localparam int OPC_W    = 3;

    typedef enum logic [OPC_W-1:0] {
        OPC_ADD    = 3'd0,
        OPC_CANCEL = 3'd1,
        OPC_PAUSE  = 3'd2,
        OPC_QUERY  = 3'd3,
        OPC_COUNT  = 3'd4,
        OPC_CLEAR  = 3'd5,
        OPC_TICK   = 3'd6
    } opcode_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_ADD,
        DP_FIND,
        DP_APPLY,
        DP_CLEAR,
        DP_TICK,
        DP_REARM,
        DP_SEL_INIT,
        DP_SEL_STEP,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   fired;
        logic   last;
    } dp_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic needs_div;
        logic div_busy;
        logic due_any;
        logic due_rest_zero;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: src/tts_div.sv
// Restoring divider that returns the remainder, one bit per cycle.
`default_nettype none
module tts_div
    import tts_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [TIME_BITS-1:0] dividend,
    input  wire logic [TIME_BITS-1:0] divisor,
    output logic                      busy,
    output logic [TIME_BITS-1:0]      remainder
);

    logic                 busy_reg;
    logic [DIVCNT_W-1:0]  cnt_reg;
    logic [TIME_BITS-1:0] dvd_reg;
    logic [TIME_BITS-1:0] dvs_reg;
    logic [TIME_BITS-1:0] acc_reg;
    logic [TIME_BITS:0]   trial;
    logic [TIME_BITS:0]   diff;

    assign trial = {acc_reg, dvd_reg[TIME_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIVCNT_W'(TIME_BITS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIVCNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            acc_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[TIME_BITS-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                acc_reg <= diff[TIME_BITS-1:0];
            end else begin
                acc_reg <= trial[TIME_BITS-1:0];
            end
        end
    end

    assign busy      = busy_reg;
    assign remainder = acc_reg;

endmodule
`default_nettype wire

// File: src/tts_datapath.sv
// Timer slot storage, tick arithmetic, id selection and the result register.
`default_nettype none
module tts_datapath
    import tts_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [OPC_W-1:0]    s_tuser,
    input  wire dp_cmd_t             cmd,
    output dp_stat_t                 stat,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tuser,
    output logic                     m_tlast
);

    // Slot storage
    logic [NUM_TIMERS-1:0] valid_reg;
    logic [NUM_TIMERS-1:0] due_reg;
    logic [ID_BITS-1:0]    ident_mem    [NUM_TIMERS];
    logic [TIME_BITS-1:0]  interval_mem [NUM_TIMERS];
    logic [TIME_BITS-1:0]  remain_mem   [NUM_TIMERS];
    logic                  repeat_mem   [NUM_TIMERS];
    logic                  unscaled_mem [NUM_TIMERS];
    logic                  paused_mem   [NUM_TIMERS];

    logic [CNT_W-1:0]      count_reg;
    logic [ID_BITS-1:0]    next_ident_reg;

    // Latched input word
    opcode_t               op_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [TIME_BITS-1:0]  delay_reg;
    logic                  rep_reg;
    logic                  uns_reg;
    logic                  pf_reg;
    logic [TIME_BITS-1:0]  sstep_reg;
    logic [TIME_BITS-1:0]  ustep_reg;

    logic [IDX_W-1:0]      idx_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [TIME_BITS-1:0]  rem_hit_reg;
    logic                  add_ok_reg;
    logic                  best_valid_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [ID_BITS-1:0]    best_ident_reg;

    logic                  m_valid_reg;
    logic [M_DATA_W-1:0]   m_data_reg;
    logic                  m_user_reg;
    logic                  m_last_reg;

    // Combinational helpers
    logic [IDX_W-1:0]      free_idx;
    logic                  free_any;
    logic                  add_ok;
    logic [TIME_BITS-1:0]  step;
    logic                  run;
    logic                  hit;
    logic [TIME_BITS-1:0]  over;
    logic                  needs_div;
    logic [NUM_TIMERS-1:0] best_mask;
    logic                  div_busy;
    logic [TIME_BITS-1:0]  div_rem;
    logic                  res_status;
    logic [ID_BITS-1:0]    res_id;
    logic [TIME_BITS-1:0]  res_rem;

    always_comb begin
        free_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign free_any = ~&valid_reg;
    assign add_ok   = free_any && !(rep_reg && (delay_reg == '0))
                      && (next_ident_reg != '1);

    assign step      = unscaled_mem[idx_reg] ? ustep_reg : sstep_reg;
    assign run       = valid_reg[idx_reg] && !paused_mem[idx_reg] && (step != '0);
    assign hit       = run && (step >= remain_mem[idx_reg]);
    assign over      = step - remain_mem[idx_reg];
    assign needs_div = hit && repeat_mem[idx_reg] && (interval_mem[idx_reg] != '0);
    assign best_mask = NUM_TIMERS'(1) << best_idx_reg;

    tts_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     ((cmd.op == DP_TICK) && needs_div),
        .dividend  (over),
        .divisor   (interval_mem[idx_reg]),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    // Fields of the result word for the current operation.
    always_comb begin
        res_status = 1'b0;
        res_id     = '0;
        res_rem    = '0;
        unique case (op_reg)
            OPC_ADD: begin
                res_status = !add_ok_reg;
                res_id     = add_ok_reg ? next_ident_reg : '0;
            end
            OPC_CANCEL, OPC_PAUSE: begin
                res_status = !found_reg;
            end
            OPC_QUERY: begin
                res_status = !found_reg;
                res_rem    = found_reg ? rem_hit_reg : '0;
            end
            OPC_COUNT, OPC_CLEAR: begin
                res_status = 1'b0;
            end
            OPC_TICK: begin
                res_id = cmd.fired ? best_ident_reg : '0;
            end
            default: begin
                res_status = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            due_reg        <= '0;
            count_reg      <= '0;
            next_ident_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.op == DP_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                DP_LOAD: begin
                    due_reg <= '0;
                end
                DP_ADD: begin
                    if (add_ok) begin
                        valid_reg[free_idx] <= 1'b1;
                        count_reg           <= count_reg + 1'b1;
                        next_ident_reg      <= next_ident_reg + 1'b1;
                    end
                end
                DP_APPLY: begin
                    if (found_reg && (op_reg == OPC_CANCEL)) begin
                        valid_reg[hit_idx_reg] <= 1'b0;
                        count_reg              <= count_reg - 1'b1;
                    end
                end
                DP_CLEAR: begin
                    valid_reg <= '0;
                    count_reg <= '0;
                end
                DP_TICK: begin
                    if (hit) begin
                        due_reg[idx_reg] <= 1'b1;
                        if (!repeat_mem[idx_reg]) begin
                            valid_reg[idx_reg] <= 1'b0;
                            count_reg          <= count_reg - 1'b1;
                        end
                    end
                end
                DP_EMIT: begin
                    if (cmd.fired) begin
                        due_reg <= due_reg & ~best_mask;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            DP_LOAD: begin
                op_reg    <= opcode_t'(s_tuser);
                id_reg    <= s_tdata[31:0];
                delay_reg <= s_tdata[63:32];
                rep_reg   <= s_tdata[64];
                uns_reg   <= s_tdata[65];
                pf_reg    <= s_tdata[66];
                sstep_reg <= s_tdata[98:67];
                ustep_reg <= s_tdata[130:99];
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            DP_ADD: begin
                add_ok_reg <= add_ok;
                if (add_ok) begin
                    ident_mem[free_idx]    <= next_ident_reg + 1'b1;
                    interval_mem[free_idx] <= delay_reg;
                    remain_mem[free_idx]   <= delay_reg;
                    repeat_mem[free_idx]   <= rep_reg;
                    unscaled_mem[free_idx] <= uns_reg;
                    paused_mem[free_idx]   <= 1'b0;
                end
            end
            DP_FIND: begin
                if (valid_reg[idx_reg] && (ident_mem[idx_reg] == id_reg)) begin
                    found_reg   <= 1'b1;
                    hit_idx_reg <= idx_reg;
                    rem_hit_reg <= remain_mem[idx_reg];
                end
                idx_reg <= idx_reg + 1'b1;
            end
            DP_APPLY: begin
                if (found_reg && (op_reg == OPC_PAUSE)) begin
                    paused_mem[hit_idx_reg] <= pf_reg;
                end
            end
            DP_TICK: begin
                if (hit) begin
                    remain_mem[idx_reg] <= '0;
                end else if (run) begin
                    remain_mem[idx_reg] <= remain_mem[idx_reg] - step;
                end
                if (!needs_div) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            DP_REARM: begin
                remain_mem[idx_reg] <= interval_mem[idx_reg] - div_rem;
                idx_reg             <= idx_reg + 1'b1;
            end
            DP_SEL_INIT: begin
                idx_reg        <= '0;
                best_valid_reg <= 1'b0;
            end
            DP_SEL_STEP: begin
                if (due_reg[idx_reg]
                    && (!best_valid_reg || (ident_mem[idx_reg] < best_ident_reg))) begin
                    best_valid_reg <= 1'b1;
                    best_idx_reg   <= idx_reg;
                    best_ident_reg <= ident_mem[idx_reg];
                end
                idx_reg <= idx_reg + 1'b1;
            end
            DP_EMIT: begin
                m_data_reg <= {2'b00, count_reg, res_rem, res_id, res_status};
                m_user_reg <= cmd.fired;
                m_last_reg <= cmd.last;
            end
            default: begin
            end
        endcase
    end

    assign stat.idx_last      = (idx_reg == IDX_W'(NUM_TIMERS - 1));
    assign stat.needs_div     = needs_div;
    assign stat.div_busy      = div_busy;
    assign stat.due_any       = |due_reg;
    assign stat.due_rest_zero = ((due_reg & ~best_mask) == '0);
    assign stat.out_free      = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

// File: src/tts_ctrl.sv
// Sequencer for the timer table scheduler.
`default_nettype none
module tts_ctrl
    import tts_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic [OPC_W-1:0] s_tuser,
    output logic                  s_tready,
    input  wire dp_stat_t         stat,
    output dp_cmd_t               cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_FIND,
        ST_APPLY,
        ST_CLEAR,
        ST_EMIT,
        ST_TICK,
        ST_DIV,
        ST_SEL_START,
        ST_SEL_SCAN,
        ST_SEL_EMIT
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   accept;

    assign accept   = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    always_comb begin
        cmd.op    = DP_NOP;
        cmd.fired = 1'b0;
        cmd.last  = 1'b1;
        unique case (state_reg)
            ST_IDLE:      if (accept) cmd.op = DP_LOAD;
            ST_ADD:       cmd.op = DP_ADD;
            ST_FIND:      cmd.op = DP_FIND;
            ST_APPLY:     cmd.op = DP_APPLY;
            ST_CLEAR:     cmd.op = DP_CLEAR;
            ST_EMIT:      if (stat.out_free) cmd.op = DP_EMIT;
            ST_TICK:      cmd.op = DP_TICK;
            ST_DIV:       if (!stat.div_busy) cmd.op = DP_REARM;
            ST_SEL_START: if (stat.due_any) cmd.op = DP_SEL_INIT;
            ST_SEL_SCAN:  cmd.op = DP_SEL_STEP;
            ST_SEL_EMIT: begin
                if (stat.out_free) cmd.op = DP_EMIT;
                cmd.fired = 1'b1;
                cmd.last  = stat.due_rest_zero;
            end
            default:      cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        ready_reg <= 1'b0;
                        unique case (opcode_t'(s_tuser))
                            OPC_ADD:                          state_reg <= ST_ADD;
                            OPC_CANCEL, OPC_PAUSE, OPC_QUERY: state_reg <= ST_FIND;
                            OPC_CLEAR:                        state_reg <= ST_CLEAR;
                            OPC_TICK:                         state_reg <= ST_TICK;
                            default:                          state_reg <= ST_EMIT;
                        endcase
                    end
                end
                ST_ADD:   state_reg <= ST_EMIT;
                ST_FIND:  if (stat.idx_last) state_reg <= ST_APPLY;
                ST_APPLY: state_reg <= ST_EMIT;
                ST_CLEAR: state_reg <= ST_EMIT;
                ST_EMIT: begin
                    if (stat.out_free) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                ST_TICK: begin
                    if (stat.needs_div) begin
                        state_reg <= ST_DIV;
                    end else if (stat.idx_last) begin
                        state_reg <= ST_SEL_START;
                    end
                end
                ST_DIV: begin
                    if (!stat.div_busy) begin
                        state_reg <= stat.idx_last ? ST_SEL_START : ST_TICK;
                    end
                end
                ST_SEL_START: state_reg <= stat.due_any ? ST_SEL_SCAN : ST_EMIT;
                ST_SEL_SCAN:  if (stat.idx_last) state_reg <= ST_SEL_EMIT;
                ST_SEL_EMIT: begin
                    if (stat.out_free) begin
                        if (stat.due_rest_zero) begin
                            state_reg <= ST_IDLE;
                            ready_reg <= 1'b1;
                        end else begin
                            state_reg <= ST_SEL_START;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: src/timer_table_scheduler.sv
// Top level of the timer table scheduler: sequencer and slot datapath.
//
// The block keeps a table of sixteen countdown timers. Each input word on
// the s_ channel carries one operation, selected by s_tuser: add, cancel,
// set pause, get remaining, get count, clear or tick. Every operation
// produces one result word on the m_ channel, except a tick, which
// produces one word per timer that fired, in ascending id order, or a
// single word if none fired; m_tlast marks the final word of the operation.
// A cancel, pause or query scans all slots. A tick walks the slots one
// a cycle, halting while a repeating timer that fires runs a remainder
// division for its rearm; each fired timer then adds a scan for the
// smallest outstanding id.
// One word is handled at a time; s_tready is high only while idle, and a
// new word is taken while the last result still waits in the output
// register. If the receiver stalls, the block holds the result word and
// waits before producing the next one. After reset the table is empty,
// the id counter is zero and the block is ready at once.
`default_nettype none
module timer_table_scheduler
    import tts_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // timer_id[31:0], delay[63:32], repeat_req[64], unscaled[65],
    // pause_flag[66], scaled_step[98:67], unscaled_step[130:99], zero fill
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // operation[2:0]
    input  wire logic [OPC_W-1:0]    s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // status[0], result_id[32:1], remaining_time[64:33],
    // active_count[69:65], zero fill
    output logic [M_DATA_W-1:0]      m_tdata,
    // fired[0]
    output logic                     m_tuser,
    // last
    output logic                     m_tlast
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The sequencer decides which datapath step runs in each cycle.
    tts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the slots, the divider and the result register.
    tts_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// File: test/timer_table_scheduler_tb.sv
// Self-checking testbench for the timer table scheduler: random and directed operations.
`timescale 1ns / 100ps
`default_nettype none
module timer_table_scheduler_tb;
    import tts_pkg::*;

    // One operation word as it is put on the s_ channel.
    typedef struct packed {
        opcode_t     opc;
        logic [31:0] timer_id;
        logic [31:0] delay;
        logic        repeat_req;
        logic        unscaled;
        logic        pause_flag;
        logic [31:0] scaled_step;
        logic [31:0] unscaled_step;
    } timer_op_t;

    // One result word as it is seen on the m_ channel.
    typedef struct packed {
        logic        status;
        logic [31:0] result_id;
        logic        fired;
        logic [31:0] remaining_time;
        logic [4:0]  active_count;
        logic        last;
    } timer_res_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [OPC_W-1:0]    s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    always #5 aclk = ~aclk;

    timer_table_scheduler i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Shadow copy of the timer table, updated as each word is accepted.
    logic        tbl_valid [NUM_TIMERS];
    logic [31:0] tbl_ident [NUM_TIMERS];
    logic [31:0] tbl_interval [NUM_TIMERS];
    logic [31:0] tbl_remaining [NUM_TIMERS];
    logic        tbl_repeat [NUM_TIMERS];
    logic        tbl_unscaled [NUM_TIMERS];
    logic        tbl_paused [NUM_TIMERS];
    logic [31:0] last_ident;

    timer_op_t  pending_ops [$];
    timer_res_t expected_results [$];
    int         fail_count = 0;
    int         send_idle_pct = 30;
    int         recv_idle_pct = 78;
    bit         hold_sender = 1'b0;
    longint     cycle_count = 0;

    // Ids are handed out in order, so the number of adds queued estimates the newest id.
    logic [31:0] last_ident_guess = 0;

    function automatic int find_timer(logic [31:0] id);
        for (int i = 0; i < NUM_TIMERS; i++)
            if (tbl_valid[i] && tbl_ident[i] == id)
                return i;
        return -1;
    endfunction

    // Applies one operation to the shadow table and queues the words it should produce.
    function automatic void predict_results(timer_op_t op);
        timer_res_t  res [$];
        timer_res_t  r;
        int          free_idx;
        int          s;
        int          best;
        logic        due [NUM_TIMERS];
        logic [31:0] rearm [NUM_TIMERS];
        logic [31:0] step;
        logic [31:0] over;
        logic [4:0]  cnt;
        r = '0;
        case (op.opc)
            OPC_ADD: begin
                free_idx = -1;
                for (int i = NUM_TIMERS - 1; i >= 0; i--)
                    if (!tbl_valid[i])
                        free_idx = i;
                if (free_idx < 0 || (op.repeat_req && op.delay == 0)
                        || last_ident == '1) begin
                    r.status = 1'b1;
                end else begin
                    last_ident = last_ident + 1;
                    tbl_valid[free_idx] = 1'b1;
                    tbl_ident[free_idx] = last_ident;
                    tbl_interval[free_idx] = op.delay;
                    tbl_remaining[free_idx] = op.delay;
                    tbl_repeat[free_idx] = op.repeat_req;
                    tbl_unscaled[free_idx] = op.unscaled;
                    tbl_paused[free_idx] = 1'b0;
                    r.result_id = last_ident;
                end
                res.push_back(r);
            end
            OPC_CANCEL, OPC_PAUSE, OPC_QUERY: begin
                s = find_timer(op.timer_id);
                r.status = (s < 0);
                if (s >= 0) begin
                    if (op.opc == OPC_CANCEL)
                        tbl_valid[s] = 1'b0;
                    else if (op.opc == OPC_PAUSE)
                        tbl_paused[s] = op.pause_flag;
                    else
                        r.remaining_time = tbl_remaining[s];
                end
                res.push_back(r);
            end
            OPC_COUNT: begin
                res.push_back(r);
            end
            OPC_CLEAR: begin
                for (int i = 0; i < NUM_TIMERS; i++)
                    tbl_valid[i] = 1'b0;
                res.push_back(r);
            end
            OPC_TICK: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    due[i] = 1'b0;
                    rearm[i] = '0;
                    step = tbl_unscaled[i] ? op.unscaled_step : op.scaled_step;
                    if (tbl_valid[i] && !tbl_paused[i] && step != 0) begin
                        if (step >= tbl_remaining[i]) begin
                            over = step - tbl_remaining[i];
                            if (tbl_repeat[i])
                                rearm[i] = tbl_interval[i] - ((tbl_interval[i] != 0)
                                    ? over % tbl_interval[i] : 32'd0);
                            tbl_remaining[i] = '0;
                            due[i] = 1'b1;
                        end else begin
                            tbl_remaining[i] = tbl_remaining[i] - step;
                        end
                    end
                end
                // Fired timers are reported smallest id first.
                forever begin
                    best = -1;
                    for (int i = 0; i < NUM_TIMERS; i++)
                        if (due[i] && (best < 0 || tbl_ident[i] < tbl_ident[best]))
                            best = i;
                    if (best < 0)
                        break;
                    due[best] = 1'b0;
                    if (tbl_repeat[best])
                        tbl_remaining[best] = rearm[best];
                    else
                        tbl_valid[best] = 1'b0;
                    r = '0;
                    r.result_id = tbl_ident[best];
                    r.fired = 1'b1;
                    res.push_back(r);
                end
                if (res.size() == 0)
                    res.push_back('0);
            end
            default: begin
                r.status = 1'b1;
                res.push_back(r);
            end
        endcase
        cnt = 0;
        for (int i = 0; i < NUM_TIMERS; i++)
            cnt += tbl_valid[i];
        foreach (res[k]) begin
            res[k].active_count = cnt;
            res[k].last = (k == res.size() - 1);
            expected_results.push_back(res[k]);
        end
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_op(timer_op_t op);
        logic [S_DATA_W-1:0] d;
        d = '0;
        d[31:0]   = op.timer_id;
        d[63:32]  = op.delay;
        d[64]     = op.repeat_req;
        d[65]     = op.unscaled;
        d[66]     = op.pause_flag;
        d[98:67]  = op.scaled_step;
        d[130:99] = op.unscaled_step;
        return d;
    endfunction

    // Driver: presents the next pending word, keeping tvalid high until it is taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_results(pending_ops.pop_front());
            end
            if (!(s_tvalid && !s_tready)) begin
                if (pending_ops.size() > 0 && !hold_sender
                        && $urandom_range(99) >= send_idle_pct
                        && !(s_tvalid && s_tready && pending_ops.size() == 0)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_op(pending_ops[0]);
                    s_tuser  <= pending_ops[0].opc;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compares every accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        timer_res_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tdata[0] !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[32:1] !== exp_r.result_id) begin
                    $error("result_id expected %0d actual %0d", exp_r.result_id,
                        m_tdata[32:1]);
                    fail_count++;
                end
                if (m_tuser !== exp_r.fired) begin
                    $error("fired expected %0d actual %0d", exp_r.fired, m_tuser);
                    fail_count++;
                end
                if (m_tdata[64:33] !== exp_r.remaining_time) begin
                    $error("remaining_time expected %0d actual %0d",
                        exp_r.remaining_time, m_tdata[64:33]);
                    fail_count++;
                end
                if (m_tdata[69:65] !== exp_r.active_count) begin
                    $error("active_count expected %0d actual %0d",
                        exp_r.active_count, m_tdata[69:65]);
                    fail_count++;
                end
                if (m_tlast !== exp_r.last) begin
                    $error("last expected %0d actual %0d", exp_r.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a tick scans every slot, and stalls stretch every word further.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic timer_op_t make_op(opcode_t opc);
        timer_op_t op;
        op = '0;
        op.opc = opc;
        return op;
    endfunction

    // Random step, mostly small so that timers fire now and then, sometimes huge.
    function automatic logic [31:0] rand_time();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return $urandom;
            2: return $urandom_range(32'h0008_0000);
            default: return $urandom_range(32'h0001_0000, 32'h0000_0001);
        endcase
    endfunction

    // A random word, weighted towards adds and ticks on ids that are likely present.
    function automatic timer_op_t rand_op();
        timer_op_t op;
        int        sel;
        op = '0;
        sel = $urandom_range(99);
        if (sel < 30)
            op.opc = OPC_ADD;
        else if (sel < 40)
            op.opc = OPC_CANCEL;
        else if (sel < 50)
            op.opc = OPC_PAUSE;
        else if (sel < 60)
            op.opc = OPC_QUERY;
        else if (sel < 63)
            op.opc = OPC_COUNT;
        else if (sel < 65)
            op.opc = OPC_CLEAR;
        else if (sel < 67)
            op.opc = opcode_t'(3'd7);
        else
            op.opc = OPC_TICK;
        op.timer_id = ($urandom_range(7) == 0) ? $urandom
            : last_ident_guess - $urandom_range(20);
        op.delay = rand_time();
        op.repeat_req = 1'($urandom);
        op.unscaled = 1'($urandom);
        op.pause_flag = 1'($urandom);
        op.scaled_step = rand_time();
        op.unscaled_step = rand_time();
        return op;
    endfunction

    task automatic queue_op(timer_op_t op);
        if (op.opc == OPC_ADD)
            last_ident_guess++;
        pending_ops.push_back(op);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        timer_op_t op;
        for (int i = 0; i < NUM_TIMERS; i++)
            tbl_valid[i] = 1'b0;
        last_ident = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: every operation, rejections, unknown ids and edge values.
        queue_op(make_op(OPC_COUNT));
        op = make_op(OPC_TICK);
        op.scaled_step = '1;
        op.unscaled_step = '1;
        queue_op(op);
        op = make_op(OPC_ADD);
        op.repeat_req = 1'b1;
        queue_op(op);                       // repeating with zero delay is refused
        op = make_op(OPC_ADD);
        op.delay = '1;
        op.repeat_req = 1'b1;
        queue_op(op);
        op = make_op(OPC_ADD);
        op.delay = 32'h0001_0000;
        op.unscaled = 1'b1;
        queue_op(op);
        op = make_op(OPC_ADD);
        op.delay = 32'h0000_0003;
        op.repeat_req = 1'b1;
        queue_op(op);
        op = make_op(OPC_ADD);
        queue_op(op);                       // zero delay one-shot fires on the first tick with a nonzero step
        op = make_op(OPC_QUERY);
        op.timer_id = 32'd1;
        queue_op(op);
        op.timer_id = '1;
        queue_op(op);
        op = make_op(OPC_PAUSE);
        op.timer_id = 32'd1;
        op.pause_flag = 1'b1;
        queue_op(op);
        op.timer_id = 32'd0;
        queue_op(op);
        op = make_op(OPC_TICK);
        op.scaled_step = 32'd0;
        op.unscaled_step = 32'h0002_0000;
        queue_op(op);
        op.scaled_step = '1;                // large overshoot, fires once only
        op.unscaled_step = '1;
        queue_op(op);
        op = make_op(OPC_PAUSE);
        op.timer_id = 32'd1;
        queue_op(op);
        op = make_op(OPC_CANCEL);
        op.timer_id = 32'd3;
        queue_op(op);
        queue_op(op);
        queue_op(make_op(opcode_t'(3'd7)));
        for (int i = 0; i < NUM_TIMERS + 1; i++) begin
            op = make_op(OPC_ADD);
            op.delay = 32'h0000_1000 * (i + 1);
            op.repeat_req = i[0];
            queue_op(op);                   // the last two meet a full table
        end
        op = make_op(OPC_TICK);
        op.scaled_step = 32'h000F_FFFF;
        op.unscaled_step = 32'h000F_FFFF;
        queue_op(op);
        queue_op(make_op(OPC_COUNT));
        queue_op(make_op(OPC_CLEAR));

        // Random part in three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 78 : 0;
            recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 30 : 0;
            for (int n = 0; n < 120; n++) begin
                queue_op(rand_op());
                if (n == 60) begin
                    // Queuing holds off until every pending word is sent and every result has come back.
                    wait_drained();
                    hold_sender = 1'b0;
                end
            end
        end
        wait_drained();
        repeat (900) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
